/* hdl/rtoh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV package
// Widths, fixed-point constants and shared types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rtoh_pkg;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 6;

    localparam int HUE_BITS   = 9 + HUE_FRACTION_BITS;
    localparam int QUO_BITS   = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
    localparam int DIV_N_BITS = QUO_BITS + CHANNEL_BITS;
    localparam int NUM_BITS   = CHANNEL_BITS + 3;
    localparam int HUE_SCALE  = 60 << HUE_FRACTION_BITS;
    localparam int HUE_LIMIT  = 360 << HUE_FRACTION_BITS;
    localparam int PIPE_DEPTH = QUO_BITS + 4;

    typedef logic [CHANNEL_BITS-1:0]      t_chan;
    typedef logic signed [CHANNEL_BITS:0] t_sdiff;
    typedef logic [NUM_BITS-1:0]          t_num;
    typedef logic signed [NUM_BITS:0]     t_snum;
    typedef logic [DIV_N_BITS-1:0]        t_dividend;
    typedef logic [QUO_BITS-1:0]          t_quo;
    typedef logic [HUE_BITS-1:0]          t_hue;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

/* hdl/rgb_to_hsv_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one pixel of red, green and blue into hue, saturation and value.
//
//   Channel | Valid    | Stall    | Payload
//   --------+----------+----------+----------------------------------------
//   input   | i_valid  | o_stall  | i_red, i_green, i_blue
//   output  | o_valid  | i_stall  | o_hue, o_saturation, o_brightness
//
// One item is taken per cycle while no result is stalled at the output; the
// pipeline depth is set by the one-bit-per-stage dividers for hue and saturation.
// The whole pipeline advances together and holds only while a result waits
// at the output under stall, so no item is lost or repeated.
// Reset clears every valid bit.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rtoh_pkg::t_chan     i_red,
    input  rtoh_pkg::t_chan     i_green,
    input  rtoh_pkg::t_chan     i_blue,
    output logic                o_valid,
    input  logic                i_stall,
    output rtoh_pkg::t_hue      o_hue,
    output rtoh_pkg::t_chan     o_saturation,
    output rtoh_pkg::t_chan     o_brightness
);

    logic                  r_vld [0:rtoh_pkg::PIPE_DEPTH-1];
    logic                  w_adv;

    rtoh_pkg::t_chan       w_max;
    rtoh_pkg::t_chan       w_min;
    rtoh_pkg::t_sector     w_sector;
    rtoh_pkg::t_sdiff      w_diff;

    rtoh_pkg::t_chan       r1_mx;
    rtoh_pkg::t_chan       r1_delta;
    rtoh_pkg::t_sector     r1_sector;
    rtoh_pkg::t_sdiff      r1_diff;

    rtoh_pkg::t_snum       w_dext;
    rtoh_pkg::t_snum       w_base;
    rtoh_pkg::t_snum       w_pre;
    rtoh_pkg::t_snum       w_wrap;

    rtoh_pkg::t_chan       r2_mx;
    rtoh_pkg::t_num        r2_num;
    rtoh_pkg::t_dividend   r2_sat_dvd;
    rtoh_pkg::t_chan       r2_hue_dvs;
    rtoh_pkg::t_chan       r2_sat_dvs;

    rtoh_pkg::t_dividend   w_hue_dvd;
    rtoh_pkg::t_quo        w_hue_q;
    rtoh_pkg::t_quo        w_sat_q;

    rtoh_pkg::t_chan       r_mx_line [0:rtoh_pkg::QUO_BITS];
    rtoh_pkg::t_hue        r_hue;
    rtoh_pkg::t_chan       r_sat;
    rtoh_pkg::t_chan       r_bright;

    assign w_adv   = !(r_vld[rtoh_pkg::PIPE_DEPTH-1] && i_stall);
    assign o_stall = r_vld[rtoh_pkg::PIPE_DEPTH-1] && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rtoh_pkg::PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < rtoh_pkg::PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            w_sector = rtoh_pkg::SEC_RED;
            w_max    = i_red;
            w_diff   = rtoh_pkg::t_sdiff'({1'b0, i_green}) - rtoh_pkg::t_sdiff'({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            w_sector = rtoh_pkg::SEC_GREEN;
            w_max    = i_green;
            w_diff   = rtoh_pkg::t_sdiff'({1'b0, i_blue}) - rtoh_pkg::t_sdiff'({1'b0, i_red});
        end else begin
            w_sector = rtoh_pkg::SEC_BLUE;
            w_max    = i_blue;
            w_diff   = rtoh_pkg::t_sdiff'({1'b0, i_red}) - rtoh_pkg::t_sdiff'({1'b0, i_green});
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            w_min = i_red;
        end else if (i_green <= i_blue) begin
            w_min = i_green;
        end else begin
            w_min = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mx     <= w_max;
            r1_delta  <= w_max - w_min;
            r1_sector <= w_sector;
            r1_diff   <= w_diff;
        end
    end

    always_comb begin
        w_dext = rtoh_pkg::t_snum'(r1_delta);
        case (r1_sector)
            rtoh_pkg::SEC_GREEN: w_base = w_dext <<< 1;
            rtoh_pkg::SEC_BLUE:  w_base = w_dext <<< 2;
            default:             w_base = '0;
        endcase
        w_pre = w_base + rtoh_pkg::t_snum'(r1_diff);
        if (w_pre[rtoh_pkg::NUM_BITS]) begin
            w_wrap = w_pre + (w_dext <<< 2) + (w_dext <<< 1);
        end else begin
            w_wrap = w_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_mx      <= r1_mx;
            r2_num     <= w_wrap[rtoh_pkg::NUM_BITS-1:0];
            r2_sat_dvd <= (rtoh_pkg::t_dividend'(r1_delta) << rtoh_pkg::CHANNEL_BITS)
                          - rtoh_pkg::t_dividend'(r1_delta);
            r2_hue_dvs <= (r1_delta == '0) ? rtoh_pkg::t_chan'(1) : r1_delta;
            r2_sat_dvs <= (r1_mx == '0) ? rtoh_pkg::t_chan'(1) : r1_mx;
        end
    end

    assign w_hue_dvd = rtoh_pkg::t_dividend'(rtoh_pkg::t_dividend'(r2_num)
                       * rtoh_pkg::t_dividend'(rtoh_pkg::HUE_SCALE));

    rtoh_div u_hue_div (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (w_hue_dvd),
        .i_divisor  (r2_hue_dvs),
        .o_quotient (w_hue_q)
    );

    rtoh_div u_sat_div (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (r2_sat_dvd),
        .i_divisor  (r2_sat_dvs),
        .o_quotient (w_sat_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mx_line[0] <= r2_mx;
            for (int k = 1; k <= rtoh_pkg::QUO_BITS; k++) begin
                r_mx_line[k] <= r_mx_line[k-1];
            end
            r_hue    <= w_hue_q[rtoh_pkg::HUE_BITS-1:0];
            r_sat    <= w_sat_q[rtoh_pkg::CHANNEL_BITS-1:0];
            r_bright <= r_mx_line[rtoh_pkg::QUO_BITS];
        end
    end

    assign o_valid      = r_vld[rtoh_pkg::PIPE_DEPTH-1];
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

endmodule

/* hdl/rtoh_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Takes one dividend and divisor each enabled cycle and gives the quotient
// one bit per stage, after an input register for dividend and divisor.
// The quotient must fit in QUO_BITS and the divisor must not be zero.
// ----------------------------------------------------------------------------
module rtoh_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  rtoh_pkg::t_dividend i_dividend,
    input  rtoh_pkg::t_chan    i_divisor,
    output rtoh_pkg::t_quo     o_quotient
);

    rtoh_pkg::t_chan r_rem [0:rtoh_pkg::QUO_BITS-1];
    rtoh_pkg::t_quo  r_low [0:rtoh_pkg::QUO_BITS-1];
    rtoh_pkg::t_chan r_dvs [0:rtoh_pkg::QUO_BITS-1];
    rtoh_pkg::t_quo  r_quo [1:rtoh_pkg::QUO_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_dividend[rtoh_pkg::DIV_N_BITS-1:rtoh_pkg::QUO_BITS];
            r_low[0] <= i_dividend[rtoh_pkg::QUO_BITS-1:0];
            r_dvs[0] <= i_divisor;
        end
    end

    for (genvar s = 1; s <= rtoh_pkg::QUO_BITS; s++) begin : g_stage
        logic [rtoh_pkg::CHANNEL_BITS:0] w_sh;
        logic [rtoh_pkg::CHANNEL_BITS:0] w_sub;
        logic                            w_ge;
        rtoh_pkg::t_chan                 n_rem;
        rtoh_pkg::t_quo                  n_quo;

        always_comb begin
            w_sh  = {r_rem[s-1], r_low[s-1][rtoh_pkg::QUO_BITS-1]};
            w_sub = w_sh - {1'b0, r_dvs[s-1]};
            w_ge  = (w_sh >= {1'b0, r_dvs[s-1]});
            n_rem = w_ge ? w_sub[rtoh_pkg::CHANNEL_BITS-1:0]
                         : w_sh[rtoh_pkg::CHANNEL_BITS-1:0];
        end

        if (s == 1) begin : g_first
            assign n_quo = rtoh_pkg::t_quo'(w_ge);
        end else begin : g_next
            assign n_quo = {r_quo[s-1][rtoh_pkg::QUO_BITS-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= n_quo;
            end
        end

        if (s < rtoh_pkg::QUO_BITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= n_rem;
                    r_low[s] <= r_low[s-1] << 1;
                    r_dvs[s] <= r_dvs[s-1];
                end
            end
        end
    end

    assign o_quotient = r_quo[rtoh_pkg::QUO_BITS];

endmodule

/* hdl/rtoh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV port checker
// Watches the ports of the converter and checks result ranges, stall
// behavior and reset.
// ----------------------------------------------------------------------------
module rtoh_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input rtoh_pkg::t_chan i_red,
    input rtoh_pkg::t_chan i_green,
    input rtoh_pkg::t_chan i_blue,
    input logic            o_valid,
    input logic            i_stall,
    input rtoh_pkg::t_hue  o_hue,
    input rtoh_pkg::t_chan o_saturation,
    input rtoh_pkg::t_chan o_brightness
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid right after reset.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("Input stalled while no result was held.");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < rtoh_pkg::HUE_LIMIT))
        else $error("Hue out of range.");

    a_black_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brightness == '0) |-> (o_hue == '0 && o_saturation == '0))
        else $error("Black pixel gave nonzero hue or saturation.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_hue)
            && $stable(o_saturation) && $stable(o_brightness)))
        else $error("Stalled result changed.");

endmodule

bind rgb_to_hsv_converter_top rtoh_checker u_rtoh_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_red        (i_red),
    .i_green      (i_green),
    .i_blue       (i_blue),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_hue        (o_hue),
    .o_saturation (o_saturation),
    .o_brightness (o_brightness)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Feeds pixels into the converter and checks each hue, saturation and value
// result against a local integer conversion of the same pixel. The run starts
// with the corner colors and then sends random pixels. Random gaps on the
// input side and random stalls on the output side are mixed with stretches
// at full rate.
// ----------------------------------------------------------------------------
module tb;

    typedef rtoh_pkg::t_chan   t_chan;
    typedef rtoh_pkg::t_hue    t_hue;
    typedef rtoh_pkg::t_sector t_sector;

    localparam int RANDOM_PIXELS = 1300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int CHAN_MAX      = (1 << rtoh_pkg::CHANNEL_BITS) - 1;

    typedef struct {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_pixel;

    typedef struct {
        t_hue  hue;
        t_chan saturation;
        t_chan brightness;
    } t_hsv;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_chan i_red   = '0;
    t_chan i_green = '0;
    t_chan i_blue  = '0;
    logic  o_stall;
    logic  o_valid;
    t_hue  o_hue;
    t_chan o_saturation;
    t_chan o_brightness;

    t_pixel pixel_q[$];
    t_hsv   expected_hsv_q[$];
    int     error_count = 0;
    int     send_idle   = 0;
    int     send_calm   = 0;
    int     hold_left   = 0;
    int     hold_calm   = 0;
    int     quiet_count = 0;

    rgb_to_hsv_converter_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_hsv rgb_to_hsv(input t_pixel px);
        int      r, g, b, top, bottom, delta, num;
        t_sector sector;
        t_hsv    res;
        r = px.red;
        g = px.green;
        b = px.blue;
        top    = (r > g) ? r : g;
        top    = (top > b) ? top : b;
        bottom = (r < g) ? r : g;
        bottom = (bottom < b) ? bottom : b;
        delta  = top - bottom;
        res.hue        = '0;
        res.saturation = '0;
        res.brightness = t_chan'(top);
        if (top > 0) begin
            res.saturation = t_chan'((CHAN_MAX * delta) / top);
            if (delta > 0) begin
                if (r >= top) begin
                    sector = rtoh_pkg::SEC_RED;
                end else if (g >= top) begin
                    sector = rtoh_pkg::SEC_GREEN;
                end else begin
                    sector = rtoh_pkg::SEC_BLUE;
                end
                case (sector)
                    rtoh_pkg::SEC_RED: begin
                        num = g - b;
                    end
                    rtoh_pkg::SEC_GREEN: begin
                        num = 2 * delta + (b - r);
                    end
                    default: begin
                        num = 4 * delta + (r - g);
                    end
                endcase
                num = num * rtoh_pkg::HUE_SCALE;
                if (num < 0) begin
                    num = num + rtoh_pkg::HUE_LIMIT * delta;
                end
                res.hue = t_hue'(num / delta);
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_chan near(input t_chan base, input int spread);
        int v;
        v = int'(base) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) begin
            v = 0;
        end else if (v > CHAN_MAX) begin
            v = CHAN_MAX;
        end
        return t_chan'(v);
    endfunction

    // Input driver.
    always @(posedge i_clk) begin
        t_pixel px;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                if (send_calm > 0) begin
                    send_calm--;
                    send_idle = 0;
                end else begin
                    send_idle = pick_gap();
                    if ($urandom_range(0, 39) == 0) begin
                        send_calm = $urandom_range(50, 150);
                    end
                end
            end
            if (send_idle > 0) begin
                send_idle--;
                i_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                px = pixel_q.pop_front();
                i_valid <= 1'b1;
                i_red   <= px.red;
                i_green <= px.green;
                i_blue  <= px.blue;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Output stall generator.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_calm > 0) begin
            hold_calm--;
            i_stall <= 1'b0;
        end else begin
            i_stall <= 1'b0;
            hold_left = pick_gap();
            if ($urandom_range(0, 49) == 0) begin
                hold_calm = $urandom_range(50, 150);
            end
        end
    end

    // Monitor: checks results first, then records the item taken at this edge.
    always @(posedge i_clk) begin
        t_hsv   want;
        t_pixel seen;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_hsv_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result hue %0d sat %0d val %0d",
                         $time, o_hue, o_saturation, o_brightness);
            end else begin
                want = expected_hsv_q.pop_front();
                if (o_hue !== want.hue) begin
                    error_count++;
                    $display("%0t: hue expected %0d got %0d",
                             $time, want.hue, o_hue);
                end
                if (o_saturation !== want.saturation) begin
                    error_count++;
                    $display("%0t: saturation expected %0d got %0d",
                             $time, want.saturation, o_saturation);
                end
                if (o_brightness !== want.brightness) begin
                    error_count++;
                    $display("%0t: brightness expected %0d got %0d",
                             $time, want.brightness, o_brightness);
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            seen.red   = i_red;
            seen.green = i_green;
            seen.blue  = i_blue;
            expected_hsv_q.push_back(rgb_to_hsv(seen));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("rgb_to_hsv_converter_top verification failed");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        t_pixel px;
        t_chan  base;
        t_chan  corners[20][3] = '{
            '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
            '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
            '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
            '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
            '{8'd128, 8'd128, 8'd128}, '{8'd1,   8'd1,   8'd1},
            '{8'd1,   8'd0,   8'd0},   '{8'd255, 8'd254, 8'd0},
            '{8'd0,   8'd1,   8'd255}, '{8'd255, 8'd0,   8'd1},
            '{8'd200, 8'd50,  8'd100}, '{8'd255, 8'd0,   8'd254},
            '{8'd1,   8'd0,   8'd1},   '{8'd254, 8'd255, 8'd0},
            '{8'd170, 8'd85,  8'd255}, '{8'd254, 8'd255, 8'd255}
        };
        foreach (corners[k]) begin
            px.red   = corners[k][0];
            px.green = corners[k][1];
            px.blue  = corners[k][2];
            pixel_q.push_back(px);
        end
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            base = t_chan'($urandom);
            case ($urandom_range(0, 9))
                5: begin
                    px.red   = near(base, 2);
                    px.green = near(base, 2);
                    px.blue  = near(base, 2);
                end
                6: begin
                    px.red   = base;
                    px.green = base;
                    px.blue  = base;
                    case ($urandom_range(0, 2))
                        0: px.red   = near(base, 255) & base;
                        1: px.green = near(base, 255) & base;
                        default: px.blue = near(base, 255) & base;
                    endcase
                end
                7: begin
                    px.red   = $urandom_range(0, 1) ? t_chan'(CHAN_MAX) : t_chan'($urandom);
                    px.green = $urandom_range(0, 1) ? t_chan'(0) : t_chan'($urandom);
                    px.blue  = $urandom_range(0, 1) ? t_chan'(CHAN_MAX) : t_chan'($urandom);
                end
                8: begin
                    px.red   = t_chan'($urandom_range(0, 15));
                    px.green = t_chan'($urandom_range(0, 15));
                    px.blue  = t_chan'($urandom_range(0, 15));
                end
                default: begin
                    px.red   = t_chan'($urandom);
                    px.green = t_chan'($urandom);
                    px.blue  = t_chan'($urandom);
                end
            endcase
            pixel_q.push_back(px);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pixel_q.size() > 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (expected_hsv_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (rtoh_pkg::PIPE_DEPTH + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("rgb_to_hsv_converter_top verification clean");
        end else begin
            $display("rgb_to_hsv_converter_top verification failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
hdl/rtoh_pkg.sv
hdl/rtoh_div.sv
hdl/rgb_to_hsv_converter_top.sv
hdl/rtoh_checker.sv
tb/tb.sv
